// ===== rtl/ccld_pkg.sv =====
package ccld_pkg;

    localparam logic [7:0] LF_BYTE    = 8'd10;
    localparam logic [7:0] SPACE_BYTE = 8'd32;
    localparam int unsigned MAX_LINE  = 100;

    typedef logic [0:15][7:0] kw_t;

    localparam kw_t KW_READALARM = '{"R", "E", "A", "D", "A", "L", "A", "R", "M",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam kw_t KW_READTIME  = '{"R", "E", "A", "D", "T", "I", "M", "E",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam kw_t KW_SETTIME   = '{"S", "E", "T", "T", "I", "M", "E",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam kw_t KW_SETALARM  = '{"S", "E", "T", "A", "L", "A", "R", "M",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    typedef enum logic [2:0] {
        ST_ALARM_READ = 3'd0,
        ST_TIME_READ  = 3'd1,
        ST_TIME_SET   = 3'd2,
        ST_ALARM_SET  = 3'd3,
        ST_VALID      = 3'd4,
        ST_INVALID    = 3'd5
    } status_t;

    // one decoded line, or one result item
    typedef struct packed {
        status_t     status;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } line_rec_t;

endpackage

// ===== rtl/ccld_fifo.sv =====
module ccld_fifo
#(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/ccld_front.sv =====
module ccld_front
    import ccld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic [7:0] rx_byte,
    output logic      full,
    input  logic      rec_full,
    output logic      rec_push,
    output line_rec_t rec
);

    logic [6:0] pos_reg, pos_next;
    logic       space_reg, space_next;
    logic [3:0] offset_reg, offset_next;
    logic [3:0] flags_reg, flags_next;
    logic       overlong_reg, overlong_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] hour_reg, hour_next;
    logic [7:0] minute_reg, minute_next;
    logic [7:0] second_reg, second_next;

    logic       accept;
    logic       is_lf;
    logic [7:0] pair;
    logic       bad_line;

    function automatic logic kw_ok(input kw_t kw, input logic [3:0] len,
                                   input logic [6:0] pos, input logic [7:0] c);
        logic in_range;
        in_range = (pos < {3'b000, len});
        return in_range && (kw[pos[3:0]] == c);
    endfunction

    // 10*(c1-48)+(c2-48), held as 255 outside 0..255
    function automatic logic [7:0] pair_value(input logic [7:0] c1, input logic [7:0] c2);
        logic [11:0] sum;
        logic [11:0] diff;
        sum  = {1'b0, c1, 3'b000} + {3'b000, c1, 1'b0} + {4'h0, c2};
        diff = sum - 12'd528;
        if (sum < 12'd528 || sum > 12'd783)
        begin
            return 8'd255;
        end
        return diff[7:0];
    endfunction

    assign full   = rec_full;
    assign accept = push && !rec_full;
    assign is_lf  = (rx_byte == LF_BYTE);
    assign pair   = pair_value(first_reg, rx_byte);

    always_comb
    begin
        pos_next      = pos_reg;
        space_next    = space_reg;
        offset_next   = offset_reg;
        flags_next    = flags_reg;
        overlong_next = overlong_reg;
        first_next    = first_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;

        if (accept && is_lf)
        begin
            pos_next      = '0;
            space_next    = 1'b0;
            offset_next   = '0;
            flags_next    = 4'hF;
            overlong_next = 1'b0;
            first_next    = '0;
            hour_next     = '0;
            minute_next   = '0;
            second_next   = '0;
        end
        else if (accept)
        begin
            if ({25'd0, pos_reg} >= MAX_LINE)
            begin
                overlong_next = 1'b1;
            end
            if (pos_reg != 7'd127)
            begin
                pos_next = pos_reg + 7'd1;
            end
            if (!kw_ok(KW_READALARM, 4'd9, pos_reg, rx_byte))
            begin
                flags_next[0] = 1'b0;
            end
            if (!kw_ok(KW_READTIME, 4'd8, pos_reg, rx_byte))
            begin
                flags_next[1] = 1'b0;
            end

            if (!space_reg)
            begin
                if (rx_byte == SPACE_BYTE)
                begin
                    space_next = 1'b1;
                    if (pos_reg != 7'd7)
                    begin
                        flags_next[2] = 1'b0;
                    end
                    if (pos_reg != 7'd8)
                    begin
                        flags_next[3] = 1'b0;
                    end
                end
                else
                begin
                    if (!kw_ok(KW_SETTIME, 4'd7, pos_reg, rx_byte))
                    begin
                        flags_next[2] = 1'b0;
                    end
                    if (!kw_ok(KW_SETALARM, 4'd8, pos_reg, rx_byte))
                    begin
                        flags_next[3] = 1'b0;
                    end
                end
            end
            else
            begin
                case (offset_reg)
                    4'd0, 4'd3, 4'd6: first_next  = rx_byte;
                    4'd1:             hour_next   = pair;
                    4'd4:             minute_next = pair;
                    4'd7:             second_next = pair;
                    default:          ;
                endcase
                if (offset_reg != 4'd15)
                begin
                    offset_next = offset_reg + 4'd1;
                end
            end
        end
    end

    // classify the line that the newline closes
    assign bad_line = overlong_reg || !space_reg || (offset_reg < 4'd8) ||
                      (hour_reg > 8'd24) || (minute_reg > 8'd60) || (second_reg > 8'd60);

    always_comb
    begin
        rec_push   = accept && is_lf && (pos_reg != '0);
        rec.hour   = hour_reg[4:0];
        rec.minute = minute_reg[5:0];
        rec.second = second_reg[5:0];
        if (!overlong_reg && flags_reg[0] && pos_reg == 7'd9)
        begin
            rec.status = ST_ALARM_READ;
        end
        else if (!overlong_reg && flags_reg[1] && pos_reg == 7'd8)
        begin
            rec.status = ST_TIME_READ;
        end
        else if (bad_line)
        begin
            rec.status = ST_INVALID;
            rec.hour   = '0;
            rec.minute = '0;
            rec.second = '0;
        end
        else if (flags_reg[2])
        begin
            rec.status = ST_TIME_SET;
        end
        else if (flags_reg[3])
        begin
            rec.status = ST_ALARM_SET;
        end
        else
        begin
            rec.status = ST_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            space_reg    <= 1'b0;
            offset_reg   <= '0;
            flags_reg    <= 4'hF;
            overlong_reg <= 1'b0;
            first_reg    <= '0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            space_reg    <= space_next;
            offset_reg   <= offset_next;
            flags_reg    <= flags_next;
            overlong_reg <= overlong_next;
            first_reg    <= first_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
        end
    end

endmodule

// ===== rtl/ccld_back.sv =====
module ccld_back
    import ccld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      line_empty,
    input  line_rec_t line_rec,
    output logic      line_pop,
    input  logic      res_full,
    output logic      res_push,
    output line_rec_t res
);

    logic [4:0] clock_hour_reg, clock_hour_next;
    logic [5:0] clock_minute_reg, clock_minute_next;
    logic [5:0] clock_second_reg, clock_second_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;

    assign line_pop = !line_empty && !res_full;
    assign res_push = line_pop;

    always_comb
    begin
        res               = line_rec;
        clock_hour_next   = clock_hour_reg;
        clock_minute_next = clock_minute_reg;
        clock_second_next = clock_second_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        case (line_rec.status)
            ST_ALARM_READ:
            begin
                res.hour   = alarm_hour_reg;
                res.minute = alarm_minute_reg;
                res.second = '0;
            end
            ST_TIME_READ:
            begin
                res.hour   = clock_hour_reg;
                res.minute = clock_minute_reg;
                res.second = clock_second_reg;
            end
            ST_TIME_SET:
            begin
                if (line_pop)
                begin
                    clock_hour_next   = line_rec.hour;
                    clock_minute_next = line_rec.minute;
                    clock_second_next = line_rec.second;
                end
            end
            ST_ALARM_SET:
            begin
                res.second = '0;
                if (line_pop)
                begin
                    alarm_hour_next   = line_rec.hour;
                    alarm_minute_next = line_rec.minute;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hour_reg   <= '0;
            clock_minute_reg <= '0;
            clock_second_reg <= '0;
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
        end
        else
        begin
            clock_hour_reg   <= clock_hour_next;
            clock_minute_reg <= clock_minute_next;
            clock_second_reg <= clock_second_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
        end
    end

endmodule

// ===== rtl/clock_command_line_decoder.sv =====
// one received byte per cycle while full is low; bytes other than newline update only the line tracker
// a newline transfer's result is registered in the line queue, then in the result queue, before it
// reaches the outputs, and it waits in the line queue while the result queue is full
// sustained throughput is one byte per cycle while full is low, set by the line tracker
// full rises only when the two-entry line queue is full and the executor is blocked by the result side
// asynchronous active-low reset clears the line tracker, the stored time and alarm, and both queues
module clock_command_line_decoder
    import ccld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       pop,
    output logic       empty,
    output logic [2:0] status,
    output logic [4:0] hour_out,
    output logic [5:0] minute_out,
    output logic [5:0] second_out
);

    localparam int REC_W = $bits(line_rec_t);

    line_rec_t  front_rec, queued_rec, back_res, out_rec;
    logic       front_push, line_full, line_empty, line_pop;
    logic       res_push, res_full;
    logic [REC_W-1:0] queued_bits, out_bits;

    ccld_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .rec_full (line_full),
        .rec_push (front_push),
        .rec      (front_rec)
    );

    ccld_fifo #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_line_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_rec),
        .rd_en   (line_pop),
        .rd_data (queued_bits),
        .full    (line_full),
        .empty   (line_empty)
    );

    assign queued_rec = line_rec_t'(queued_bits);

    ccld_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_empty (line_empty),
        .line_rec   (queued_rec),
        .line_pop   (line_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res)
    );

    ccld_fifo #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_res_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (out_bits),
        .full    (res_full),
        .empty   (empty)
    );

    assign out_rec    = line_rec_t'(out_bits);
    assign status     = out_rec.status;
    assign hour_out   = out_rec.hour;
    assign minute_out = out_rec.minute;
    assign second_out = out_rec.second;

endmodule

// ===== sim/tb.sv =====
module tb;

    import ccld_pkg::*;

    typedef logic [7:0] char_q_t[$];

    localparam logic [7:0] DIGIT_ZERO = "0";
    localparam logic [7:0] COLON      = ":";
    localparam int         HOUR_MAX   = 24;
    localparam int         MINSEC_MAX = 60;
    localparam int         STALL_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] rx_byte = 8'd0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [2:0] status;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;

    clock_command_line_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .pop        (pop),
        .empty      (empty),
        .status     (status),
        .hour_out   (hour_out),
        .minute_out (minute_out),
        .second_out (second_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decoder shadow state
    logic [6:0] line_pos;
    logic       space_seen;
    logic [3:0] after_space;
    logic [3:0] word_ok;
    logic       overlong;
    logic [7:0] first_digit;
    logic [7:0] hour_val;
    logic [7:0] minute_val;
    logic [7:0] second_val;
    logic [4:0] time_hour = '0;
    logic [5:0] time_minute = '0;
    logic [5:0] time_second = '0;
    logic [4:0] alarm_hour = '0;
    logic [5:0] alarm_minute = '0;

    line_rec_t line_results[$];
    line_rec_t want;

    int mismatches = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int bytes_taken = 0;
    int quiet_cycles = 0;

    task automatic clear_line();
        line_pos    = '0;
        space_seen  = 1'b0;
        after_space = '0;
        word_ok     = 4'hF;
        overlong    = 1'b0;
        first_digit = '0;
        hour_val    = '0;
        minute_val  = '0;
        second_val  = '0;
    endtask

    function automatic logic kw_hit(kw_t kw, int unsigned len, int unsigned p, logic [7:0] c);
        if (p >= len)
            return 1'b0;
        return kw[p] == c;
    endfunction

    function automatic logic [7:0] pair_value(logic [7:0] hi, logic [7:0] lo);
        int v;
        v = 10 * (int'(hi) - int'(DIGIT_ZERO)) + (int'(lo) - int'(DIGIT_ZERO));
        if (v < 0 || v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // advance the shadow decoder by one accepted byte
    task automatic decode_rx_byte(input logic [7:0] c);
        int unsigned p;
        line_rec_t   rec;
        p = line_pos;
        if (c == LF_BYTE)
        begin
            if (line_pos == 0)
            begin
                clear_line();
                return;
            end
            rec = '{ST_INVALID, 5'd0, 6'd0, 6'd0};
            if (!overlong && word_ok[0] && line_pos == 7'd9)
                rec = '{ST_ALARM_READ, alarm_hour, alarm_minute, 6'd0};
            else if (!overlong && word_ok[1] && line_pos == 7'd8)
                rec = '{ST_TIME_READ, time_hour, time_minute, time_second};
            else if (overlong || !space_seen || after_space < 4'd8 || hour_val > HOUR_MAX
                     || minute_val > MINSEC_MAX || second_val > MINSEC_MAX)
                rec = '{ST_INVALID, 5'd0, 6'd0, 6'd0};
            else if (word_ok[2])
            begin
                rec = '{ST_TIME_SET, hour_val[4:0], minute_val[5:0], second_val[5:0]};
                time_hour   = hour_val[4:0];
                time_minute = minute_val[5:0];
                time_second = second_val[5:0];
            end
            else if (word_ok[3])
            begin
                rec = '{ST_ALARM_SET, hour_val[4:0], minute_val[5:0], 6'd0};
                alarm_hour   = hour_val[4:0];
                alarm_minute = minute_val[5:0];
            end
            else
                rec = '{ST_VALID, hour_val[4:0], minute_val[5:0], second_val[5:0]};
            line_results.push_back(rec);
            clear_line();
            return;
        end

        if (p >= MAX_LINE)
            overlong = 1'b1;
        if (p < 127)
            line_pos = line_pos + 7'd1;
        if (!kw_hit(KW_READALARM, 9, p, c))
            word_ok[0] = 1'b0;
        if (!kw_hit(KW_READTIME, 8, p, c))
            word_ok[1] = 1'b0;

        if (!space_seen)
        begin
            if (c == SPACE_BYTE)
            begin
                space_seen = 1'b1;
                if (p != 7)
                    word_ok[2] = 1'b0;
                if (p != 8)
                    word_ok[3] = 1'b0;
            end
            else
            begin
                if (!kw_hit(KW_SETTIME, 7, p, c))
                    word_ok[2] = 1'b0;
                if (!kw_hit(KW_SETALARM, 8, p, c))
                    word_ok[3] = 1'b0;
            end
            return;
        end

        case (after_space)
            4'd0, 4'd3, 4'd6: first_digit = c;
            4'd1: hour_val = pair_value(first_digit, c);
            4'd4: minute_val = pair_value(first_digit, c);
            4'd7: second_val = pair_value(first_digit, c);
            default: ;
        endcase
        if (after_space < 4'd15)
            after_space = after_space + 4'd1;
    endtask

    // push stays high between back-to-back transfers
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_rx_byte(b);
        bytes_taken++;
    endtask

    task automatic send_bytes(input char_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (line_results.size() != 0);
    endtask

    function automatic void add_text(ref char_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic void add_pair(ref char_q_t q, input int v);
        q.push_back(DIGIT_ZERO + 8'(v / 10));
        q.push_back(DIGIT_ZERO + 8'(v % 10));
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] v;
        if ($urandom_range(0, 7) == 0)
            return SPACE_BYTE;
        v = 8'($urandom_range(0, 255));
        if (v == LF_BYTE)
            v = v ^ 8'h01;
        return v;
    endfunction

    function automatic void add_field(ref char_q_t q, input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            add_pair(q, $urandom_range(0, lim));
        else if (r == 7)
            add_pair(q, lim + $urandom_range(0, 1));
        else if (r == 8)
            add_pair(q, $urandom_range(lim + 1, 99));
        else
        begin
            q.push_back(noise_char());
            q.push_back(noise_char());
        end
    endfunction

    function automatic void add_separator(ref char_q_t q);
        if ($urandom_range(0, 3) != 0)
            q.push_back(COLON);
        else
            q.push_back(noise_char());
    endfunction

    function automatic void add_set_command(ref char_q_t q);
        int n;
        case ($urandom_range(0, 3))
            0: add_text(q, "SETTIME");
            1: add_text(q, "SETALARM");
            2:
            begin
                n = $urandom_range(1, 9);
                repeat (n)
                    q.push_back("A" + 8'($urandom_range(0, 25)));
            end
            default:
                case ($urandom_range(0, 4))
                    0: add_text(q, "SETTIM");
                    1: add_text(q, "SETALARMX");
                    2: add_text(q, "READTIME");
                    3: add_text(q, "READALARM");
                    default: add_text(q, "SETTIMES");
                endcase
        endcase
        q.push_back(SPACE_BYTE);
        add_field(q, HOUR_MAX);
        add_separator(q);
        add_field(q, MINSEC_MAX);
        add_separator(q);
        add_field(q, MINSEC_MAX);
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
                q.push_back(noise_char());
        end
    endfunction

    function automatic void build_random_line(ref char_q_t q);
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 50)
            add_set_command(q);
        else if (kind < 65)
        begin
            if ($urandom_range(0, 1) == 0)
                add_text(q, "READALARM");
            else
                add_text(q, "READTIME");
            case ($urandom_range(0, 7))
                0: q.push_back(noise_char());
                1: void'(q.pop_back());
                default: ;
            endcase
        end
        else if (kind < 70)
            ;
        else if (kind < 72)
        begin
            add_text(q, "SETTIME 12:34:56");
            case ($urandom_range(0, 3))
                0: n = MAX_LINE - 1;
                1: n = MAX_LINE;
                2: n = MAX_LINE + 1;
                default: n = $urandom_range(MAX_LINE + 2, 140);
            endcase
            while (q.size() < n)
                q.push_back(noise_char());
        end
        else if (kind < 86)
        begin
            // set command cut short
            add_set_command(q);
            n = $urandom_range(1, q.size() - 1);
            while (q.size() > n)
                void'(q.pop_back());
        end
        else
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                q.push_back(noise_char());
        end
        q.push_back(LF_BYTE);
    endfunction

    task automatic send_line(input string s);
        char_q_t q;
        add_text(q, s);
        q.push_back(LF_BYTE);
        send_bytes(q);
    endtask

    task automatic send_padded(input string head, input int total);
        char_q_t q;
        add_text(q, head);
        while (q.size() < total)
            q.push_back("x");
        q.push_back(LF_BYTE);
        send_bytes(q);
    endtask

    task automatic test_reads_after_reset();
        send_byte(LF_BYTE);
        send_line("READALARM");
        send_line("READTIME");
    endtask

    task automatic test_set_and_read();
        send_line("SETTIME 24:60:60");
        wait_drained();
        send_line("READTIME");
        send_line("SETALARM 00:00:00");
        send_line("READALARM");
        send_line("SETALARM 24:60:59");
        send_line("READALARM");
        send_line("SETTIME 00:00:00trailing");
        send_line("READTIME");
        send_line("FOO 12:34:56");
        send_line("SET TIME 12:34:56");
    endtask

    task automatic test_malformed_lines();
        char_q_t q;
        send_line("SETTIME 25:00:00");
        send_line("SETTIME 00:61:00");
        send_line("SETTIME 00:00:61");
        send_line("SETTIME");
        send_line("SETTIME 12:34:5");
        send_line("SETTIME  12:34:56");
        send_line("READTIMEX");
        send_line("READ TIME");
        // carriage return and nul are ordinary characters
        add_text(q, "READTIME");
        q.push_back(8'h0D);
        q.push_back(LF_BYTE);
        add_text(q, "SETTIME 01:02:03");
        q.push_back(8'h00);
        q.push_back(8'hFF);
        q.push_back(LF_BYTE);
        send_bytes(q);
    endtask

    task automatic test_line_length();
        send_padded("FOO 01:02:03 ", MAX_LINE);
        send_padded("FOO 01:02:03 ", MAX_LINE + 1);
        send_padded("READTIME", 140);
    endtask

    task automatic test_random_lines(input int tx_pct, input int rx_pct, input int n_bytes);
        char_q_t q;
        int      stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = bytes_taken + n_bytes;
        while (bytes_taken < stop_at)
        begin
            q.delete();
            build_random_line(q);
            send_bytes(q);
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    task automatic check_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (line_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, status, hour_out, minute_out, second_out);
                end
                else
                begin
                    want = line_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("hour", want.hour, hour_out);
                    check_field("minute", want.minute, minute_out);
                    check_field("second", want.second, second_out);
                end
            end
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("clock_command_line_decoder regression: fail");
        $finish;
    end

    initial
    begin
        clear_line();
        tx_idle_pct = 28;
        rx_idle_pct = 51;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reads_after_reset();
        test_set_and_read();
        test_malformed_lines();
        test_line_length();
        test_random_lines(28, 51, 150);
        test_random_lines(51, 28, 150);
        test_random_lines(0, 0, 150);
        push <= 1'b0;
        while (line_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("clock_command_line_decoder regression: pass");
        else
            $display("clock_command_line_decoder regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ccld_pkg.sv
rtl/ccld_fifo.sv
rtl/ccld_front.sv
rtl/ccld_back.sv
rtl/clock_command_line_decoder.sv
sim/tb.sv
